>>> hdl/crp_pkg.sv
// Shared constants, codes and types for the scalar-to-colour ramp.
package crp_pkg;

   // Default sample and range register width
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Quotient bits per colour component, one divider cell per bit
   localparam int QUO_BITS = 8;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 2'd1;

   // Component levels
   localparam logic [QUO_BITS-1:0] LEVEL_FULL = 8'd255;
   localparam logic [QUO_BITS-1:0] LEVEL_NONE = 8'd0;

   // Ramp segments
   typedef enum logic [1:0] {
      SEG_BLUE_CYAN,
      SEG_CYAN_GREEN,
      SEG_GREEN_YELLOW,
      SEG_YELLOW_RED
   } seg_type;

   // Control that travels with each request down the pipeline
   typedef struct packed {
      logic    valid;
      logic    empty;
      seg_type seg;
   } ctrl_type;

endpackage

>>> hdl/crp_if.sv
// Request and response channel interfaces of the colour ramp.
interface crp_req_if #(
   parameter int SAMPLE_BITS = crp_pkg::SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source  (output valid, output sample, input ready);
   modport sink    (input valid, input sample, output ready);
   modport monitor (input valid, input ready, input sample);
endinterface

interface crp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       empty_range;

   modport source  (output valid, output red, output green, output blue,
                    output empty_range, input ready);
   modport sink    (input valid, input red, input green, input blue,
                    input empty_range, output ready);
   modport monitor (input valid, input ready, input red, input green,
                    input blue, input empty_range);
endinterface

>>> hdl/scalar_to_color_ramp.sv
// Top level of the scalar-to-colour ramp: front stages, divider chain, output.
//
// Maps each unsigned sample to an 8-bit RGB colour on a blue, cyan, green,
// yellow, red ramp over the range [range_low, range_high].
// Channels: req_bus carries one sample per request; rsp_bus returns red,
// green, blue and empty_range. A request is taken when valid and ready are
// both high. The range registers are written through csr_wr_en, csr_index
// and csr_wdata (index 0 range_low, 1 range_high, others ignored); the user
// must write them only while the block is idle; the block does not enforce it.
// Pipeline: two front stages (clip, segment and dividend), eight divider
// cells that each resolve one quotient bit, and the response register.
// Throughput: one request per cycle while no response waits untaken; the
// whole pipeline moves together. When the receiver holds rsp_bus.ready low
// with a response waiting, the pipeline freezes and req_bus.ready drops in
// the same cycle; no response is lost or repeated.
// Reset: all stages are emptied, range_low returns to 0 and range_high to
// all ones. An empty range (range_high not above range_low) gives pure blue
// with empty_range set.
module scalar_to_color_ramp #(
   parameter int SAMPLE_BITS = crp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   crp_req_if.sink                             req_bus,
   crp_rsp_if.source                           rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [crp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_wdata
);
   import crp_pkg::*;

   localparam int RW = SAMPLE_BITS + 9;

   // Range registers
   logic [SAMPLE_BITS-1:0] range_low_ff;
   logic [SAMPLE_BITS-1:0] range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_LOW: begin
               range_low_ff <= csr_wdata;
            end
            CSR_RANGE_HIGH: begin
               range_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline moves whenever the response register is free or being taken
   logic rsp_valid_ff;
   logic advance;

   assign advance       = ~rsp_valid_ff | rsp_bus.ready;
   assign req_bus.ready = advance;

   // Divider chain links
   ctrl_type             chain_ctrl [QUO_BITS+1];
   logic [RW-1:0]        chain_rem  [QUO_BITS+1];
   logic [SAMPLE_BITS:0] chain_dvs  [QUO_BITS+1];
   logic [QUO_BITS-1:0]  chain_quo  [QUO_BITS+1];

   crp_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_bus.valid),
      .sample     (req_bus.sample),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_ctrl   (chain_ctrl[0]),
      .out_rem    (chain_rem[0]),
      .out_dvs    (chain_dvs[0])
   );

   assign chain_quo[0] = '0;

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      crp_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .SHIFT       (QUO_BITS - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctrl (chain_ctrl[i]),
         .up_rem  (chain_rem[i]),
         .up_dvs  (chain_dvs[i]),
         .up_quo  (chain_quo[i]),
         .dn_ctrl (chain_ctrl[i+1]),
         .dn_rem  (chain_rem[i+1]),
         .dn_dvs  (chain_dvs[i+1]),
         .dn_quo  (chain_quo[i+1])
      );
   end

   // Colour assembly from segment and scaled component
   ctrl_type            last_ctrl;
   logic [QUO_BITS-1:0] level;
   logic [QUO_BITS-1:0] red_ff, red_in;
   logic [QUO_BITS-1:0] green_ff, green_in;
   logic [QUO_BITS-1:0] blue_ff, blue_in;
   logic                empty_ff;

   assign last_ctrl = chain_ctrl[QUO_BITS];
   assign level     = chain_quo[QUO_BITS];

   always_comb begin
      red_in   = LEVEL_NONE;
      green_in = LEVEL_NONE;
      blue_in  = LEVEL_FULL;
      if (!last_ctrl.empty) begin
         case (last_ctrl.seg)
            SEG_BLUE_CYAN: begin
               red_in   = LEVEL_NONE;
               green_in = level;
               blue_in  = LEVEL_FULL;
            end
            SEG_CYAN_GREEN: begin
               red_in   = LEVEL_NONE;
               green_in = LEVEL_FULL;
               blue_in  = level;
            end
            SEG_GREEN_YELLOW: begin
               red_in   = level;
               green_in = LEVEL_FULL;
               blue_in  = LEVEL_NONE;
            end
            SEG_YELLOW_RED: begin
               red_in   = LEVEL_FULL;
               green_in = level;
               blue_in  = LEVEL_NONE;
            end
            default: begin
               red_in   = LEVEL_NONE;
               green_in = LEVEL_NONE;
               blue_in  = LEVEL_FULL;
            end
         endcase
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         empty_ff <= last_ctrl.empty;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.red         = red_ff;
   assign rsp_bus.green       = green_ff;
   assign rsp_bus.blue        = blue_ff;
   assign rsp_bus.empty_range = empty_ff;

endmodule

>>> hdl/crp_front.sv
// Front stages: clip, range width, segment choice and dividend set-up.
module crp_front #(
   parameter int SAMPLE_BITS = crp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] range_low,
   input  logic [SAMPLE_BITS-1:0] range_high,
   output crp_pkg::ctrl_type      out_ctrl,
   output logic [SAMPLE_BITS+8:0] out_rem,
   output logic [SAMPLE_BITS:0]   out_dvs
);
   import crp_pkg::*;

   localparam int RW = SAMPLE_BITS + 9;
   localparam int TW = SAMPLE_BITS + 2;

   // Stage A: clip and offsets
   logic [SAMPLE_BITS-1:0] clip;
   ctrl_type               a_ctrl_ff, a_ctrl_in;
   logic [SAMPLE_BITS-1:0] a_d_ff, a_d_in;
   logic [SAMPLE_BITS-1:0] a_w_ff, a_w_in;

   always_comb begin
      if (sample < range_low) begin
         clip = range_low;
      end else if (sample > range_high) begin
         clip = range_high;
      end else begin
         clip = sample;
      end
      a_d_in          = clip - range_low;
      a_w_in          = range_high - range_low;
      a_ctrl_in.valid = in_valid;
      a_ctrl_in.empty = (range_high <= range_low);
      a_ctrl_in.seg   = SEG_BLUE_CYAN;
   end

   // Stage B: segment from 4*d against w, 2w, 3w; numerator and dividend
   logic [TW-1:0] t4, w1, w2, w3, w4, num;
   ctrl_type      b_ctrl_ff, b_ctrl_in;
   logic [RW-1:0] b_rem_ff, b_rem_in;
   logic [SAMPLE_BITS:0] b_dvs_ff, b_dvs_in;

   always_comb begin
      t4 = {a_d_ff, 2'b00};
      w1 = TW'(a_w_ff);
      w2 = w1 << 1;
      w3 = w1 + w2;
      w4 = w1 << 2;
      b_ctrl_in = a_ctrl_ff;
      if (t4 < w1) begin
         b_ctrl_in.seg = SEG_BLUE_CYAN;
         num           = t4;
      end else if (t4 < w2) begin
         b_ctrl_in.seg = SEG_CYAN_GREEN;
         num           = w2 - t4;
      end else if (t4 < w3) begin
         b_ctrl_in.seg = SEG_GREEN_YELLOW;
         num           = t4 - w2;
      end else begin
         b_ctrl_in.seg = SEG_YELLOW_RED;
         num           = w4 - t4;
      end
      // 510*num + w over 2w rounds 255*num/w half up
      b_rem_in = (RW'(num) << 9) - (RW'(num) << 1) + RW'(a_w_ff);
      b_dvs_in = {a_w_ff, 1'b0};
   end

   // Stage control, valid cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff.valid <= 1'b0;
         b_ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ctrl_ff <= a_ctrl_in;
         b_ctrl_ff <= b_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_d_ff          <= a_d_in;
         a_w_ff          <= a_w_in;
         b_rem_ff        <= b_rem_in;
         b_dvs_ff        <= b_dvs_in;
      end
   end

   assign out_ctrl = b_ctrl_ff;
   assign out_rem  = b_rem_ff;
   assign out_dvs  = b_dvs_ff;

endmodule

>>> hdl/crp_cell.sv
// One divider cell: resolves one quotient bit and passes the request on.
module crp_cell #(
   parameter int SAMPLE_BITS = crp_pkg::SAMPLE_BITS_DEFAULT,
   parameter int SHIFT       = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  crp_pkg::ctrl_type               up_ctrl,
   input  logic [SAMPLE_BITS+8:0]          up_rem,
   input  logic [SAMPLE_BITS:0]            up_dvs,
   input  logic [crp_pkg::QUO_BITS-1:0]    up_quo,
   output crp_pkg::ctrl_type               dn_ctrl,
   output logic [SAMPLE_BITS+8:0]          dn_rem,
   output logic [SAMPLE_BITS:0]            dn_dvs,
   output logic [crp_pkg::QUO_BITS-1:0]    dn_quo
);
   import crp_pkg::*;

   localparam int RW = SAMPLE_BITS + 9;

   logic [RW-1:0] dvs_sh;
   logic [RW:0]   diff;
   logic          take;

   ctrl_type             ctrl_ff;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [SAMPLE_BITS:0] dvs_ff;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;

   // Trial subtract of the divisor at this bit weight
   always_comb begin
      dvs_sh = RW'(up_dvs) << SHIFT;
      diff   = {1'b0, up_rem} - {1'b0, dvs_sh};
      take   = ~diff[RW];
      rem_in = take ? diff[RW-1:0] : up_rem;
      quo_in = {up_quo[QUO_BITS-2:0], take};
   end

   // Cell control, valid cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff        <= rem_in;
         dvs_ff        <= up_dvs;
         quo_ff        <= quo_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_rem  = rem_ff;
   assign dn_dvs  = dvs_ff;
   assign dn_quo  = quo_ff;

endmodule

>>> hdl/crp_checker.sv
// Port-level checks on the colour ramp and their binding to the top level.
module crp_checker (
   input logic        clock,
   input logic        reset,
   crp_req_if.sink    req_bus,
   crp_rsp_if.source  rsp_bus
);
   import crp_pkg::*;

   // Pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.red) && $stable(rsp_bus.green) &&
         $stable(rsp_bus.blue) && $stable(rsp_bus.empty_range))
      else $error("stalled response changed");

   // A stalled response stops intake in the same cycle
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while response stalled");

   // Empty range always gives pure blue
   a_empty_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.empty_range |->
         rsp_bus.red == LEVEL_NONE && rsp_bus.green == LEVEL_NONE &&
         rsp_bus.blue == LEVEL_FULL)
      else $error("empty range not blue");

   // On the ramp red and blue are never both lit
   a_ramp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.empty_range |->
         rsp_bus.red == LEVEL_NONE || rsp_bus.blue == LEVEL_NONE)
      else $error("red and blue both lit");

endmodule

bind scalar_to_color_ramp crp_checker u_crp_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

>>> sim/scalar_to_color_ramp_tb.sv
// Self-checking testbench for the scalar-to-colour ramp: random and directed requests.
module scalar_to_color_ramp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crp_pkg::*;

   localparam int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT;
   localparam int PIPE_LATENCY = 11;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_ITEMS  = 86;

   // Indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       empty_range;
   } colour_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SAMPLE_BITS-1:0]    csr_wdata;

   crp_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   crp_rsp_if                              rsp_bus ();

   // Shadow copy of the range registers
   logic [SAMPLE_BITS-1:0] range_lo;
   logic [SAMPLE_BITS-1:0] range_hi;

   logic [SAMPLE_BITS-1:0] pending_samples[$];
   colour_type             expected_colours[$];
   int                     errors;
   int                     send_idle_pct;
   int                     recv_stall_pct;

   scalar_to_color_ramp #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(255 * num / w), halves rounded up
   function automatic logic [7:0] scale255(input longint unsigned num,
                                           input longint unsigned w);
      longint unsigned q;
      q = (510 * num + w) / (2 * w);
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   // Colour expected for one sample under the current range
   function automatic colour_type ramp_colour(input logic [SAMPLE_BITS-1:0] smp);
      longint unsigned v, lo, hi, w, t;
      seg_type         seg;
      colour_type      c;
      v  = 64'(smp);
      lo = 64'(range_lo);
      hi = 64'(range_hi);
      c.empty_range = 1'b0;
      if (hi <= lo) begin
         c.red         = LEVEL_NONE;
         c.green       = LEVEL_NONE;
         c.blue        = LEVEL_FULL;
         c.empty_range = 1'b1;
         return c;
      end
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      w = hi - lo;
      t = 4 * (v - lo);
      if (t < w)          seg = SEG_BLUE_CYAN;
      else if (t < 2 * w) seg = SEG_CYAN_GREEN;
      else if (t < 3 * w) seg = SEG_GREEN_YELLOW;
      else                seg = SEG_YELLOW_RED;
      case (seg)
         SEG_BLUE_CYAN: begin
            c.red   = LEVEL_NONE;
            c.green = scale255(t, w);
            c.blue  = LEVEL_FULL;
         end
         SEG_CYAN_GREEN: begin
            c.red   = LEVEL_NONE;
            c.green = LEVEL_FULL;
            c.blue  = scale255(2 * w - t, w);
         end
         SEG_GREEN_YELLOW: begin
            c.red   = scale255(t - 2 * w, w);
            c.green = LEVEL_FULL;
            c.blue  = LEVEL_NONE;
         end
         default: begin
            c.red   = LEVEL_FULL;
            c.green = scale255(4 * w - t, w);
            c.blue  = LEVEL_NONE;
         end
      endcase
      return c;
   endfunction

   // Sample biased towards the range, its edges and its segment boundaries
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int lo, hi, w, s;
      lo = int'(range_lo);
      hi = int'(range_hi);
      w  = hi - lo;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: s = $urandom_range(lo, hi);
         6: begin
            if ($urandom_range(0, 1)) s = lo + $urandom_range(0, 6) - 3;
            else                      s = hi + $urandom_range(0, 6) - 3;
         end
         7: s = lo + (w * $urandom_range(0, 4)) / 4 + $urandom_range(0, 4) - 2;
         default: s = $urandom_range(0, SAMPLE_MAX);
      endcase
      if (s < 0) s = 0;
      if (s > SAMPLE_MAX) s = SAMPLE_MAX;
      return s[SAMPLE_BITS-1:0];
   endfunction

   // Request driver: pops pending samples, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_colours.push_back(ramp_colour(req_bus.sample));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid  <= 1'b1;
               req_bus.sample <= pending_samples.pop_front();
            end else begin
               req_bus.valid  <= 1'b0;
               req_bus.sample <= SAMPLE_BITS'($urandom);
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   // Response monitor: compares against the oldest expected colour, stalls at random
   always @(posedge clock) begin
      colour_type exp_c;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_colours.size() == 0) begin
               $display("%0t: response with none expected, actual r %0d g %0d b %0d e %0d",
                        $time, rsp_bus.red, rsp_bus.green, rsp_bus.blue,
                        rsp_bus.empty_range);
               errors++;
            end else begin
               exp_c = expected_colours.pop_front();
               check_field("red", exp_c.red, rsp_bus.red);
               check_field("green", exp_c.green, rsp_bus.green);
               check_field("blue", exp_c.blue, rsp_bus.blue);
               check_field("empty_range", {7'd0, exp_c.empty_range},
                           {7'd0, rsp_bus.empty_range});
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Wait until every request has gone through and every response is in;
   // checked just after each edge so that the driver's updates are seen
   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_bus.valid || expected_colours.size() > 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [SAMPLE_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_RANGE_LOW)  range_lo = data;
      if (idx == CSR_RANGE_HIGH) range_hi = data;
   endtask

   task automatic set_range(input int lo, input int hi);
      wait_drained();
      write_csr(CSR_RANGE_LOW, lo[SAMPLE_BITS-1:0]);
      write_csr(CSR_RANGE_HIGH, hi[SAMPLE_BITS-1:0]);
   endtask

   // Stimulus sequence
   initial begin
      int lo, hi, a, b;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      errors         = 0;
      send_idle_pct  = 15;
      recv_stall_pct = 50;
      range_lo       = '0;
      range_hi       = SAMPLE_BITS'(SAMPLE_MAX);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset range: extremes and the quarter points
      pending_samples = '{16'd0, 16'hFFFF, 16'd16383, 16'd16384, 16'd32768, 16'd49152,
                          16'd12345};
      // Three-wide range, clipping on both sides
      set_range(1000, 1003);
      pending_samples = '{16'd0, 16'd1000, 16'd1001, 16'd1002, 16'd1003, 16'hFFFF};
      // Empty range: equal bounds, then inverted bounds
      set_range(500, 500);
      pending_samples = '{16'd500, 16'hFFFF};
      set_range(SAMPLE_MAX, 0);
      pending_samples = '{16'd0, 16'hFFFF};
      // Narrowest range, then spare indexes must leave it alone
      set_range(0, 1);
      pending_samples = '{16'd0, 16'd1};
      wait_drained();
      write_csr(CSR_SPARE_2, '0);
      write_csr(CSR_SPARE_3, '1);
      pending_samples = '{16'd0, 16'd1};

      // Random phases with new ranges
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0: begin lo = 0; hi = SAMPLE_MAX; end
            1: begin
               a = $urandom_range(0, SAMPLE_MAX);
               b = $urandom_range(0, SAMPLE_MAX);
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
            end
            2: begin
               lo = $urandom_range(0, SAMPLE_MAX - 8);
               hi = lo + $urandom_range(1, 8);
            end
            3: begin
               hi = $urandom_range(0, SAMPLE_MAX);
               lo = $urandom_range(hi, SAMPLE_MAX);
            end
            4: begin lo = 0; hi = $urandom_range(1, 300); end
            default: begin lo = $urandom_range(65000, SAMPLE_MAX - 1); hi = SAMPLE_MAX; end
         endcase
         wait_drained();
         if (ph < 4) begin
            send_idle_pct  = 15;
            recv_stall_pct = 50;
         end else if (ph < 8) begin
            send_idle_pct  = 50;
            recv_stall_pct = 15;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      SAMPLE_BITS'($urandom));
         set_range(lo, hi);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold off once mid-phase until the pipeline has emptied
            if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
            pending_samples.push_back(pick_sample());
         end
      end

      wait_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (errors == 0) begin
         $display("scalar_to_color_ramp_tb: PASS");
      end else begin
         $display("scalar_to_color_ramp_tb: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("scalar_to_color_ramp_tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
hdl/crp_pkg.sv
hdl/crp_if.sv
hdl/crp_front.sv
hdl/crp_cell.sv
hdl/scalar_to_color_ramp.sv
hdl/crp_checker.sv
sim/scalar_to_color_ramp_tb.sv
